FILE: design/sds_pkg.sv
// sds_pkg: shared constants, types and codes of the SCAN disk scheduler.
// No dependencies; imported by the interfaces and every module.
package sds_pkg;

  localparam int MAX_REQUESTS = 32;
  localparam int CYL_BITS     = 16;
  localparam int SEEK_W       = 22;
  localparam int COUNT_W      = 17;
  localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COUNT_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CYL_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_UP   = 2'd2;

  localparam logic [COUNT_W-1:0] CYL_COUNT_RST = COUNT_W'(200);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_INS_CMP,
    S_RUN_INIT,
    S_SPLIT,
    S_SPLIT_CMP,
    S_EMIT,
    S_CALC,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_RUN_A,
    PH_TURN,
    PH_RUN_B
  } phase_e;

  typedef struct packed {
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [CYL_BITS-1:0] wdata;
    logic [IDX_W-1:0]    raddr;
  } mem_req_t;

  typedef struct packed {
    logic                gt;
    logic                lt;
    logic [CYL_BITS-1:0] delta;
  } alu_res_t;

endpackage

FILE: design/sds_req_if.sv
// sds_req_if: request channel (one cylinder request per transfer).
// Depends on sds_pkg.
interface sds_req_if import sds_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CYL_BITS-1:0] cylinder;
  logic                last;

  modport source (output valid, cylinder, last, input ready);
  modport sink   (input valid, cylinder, last, output ready);
endinterface

FILE: design/sds_res_if.sv
// sds_res_if: result channel (one serviced position per transfer).
// Depends on sds_pkg.
interface sds_res_if import sds_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CYL_BITS-1:0] position;
  logic                edge_visit;
  logic [SEEK_W-1:0]   seek_total;
  logic                dropped;
  logic                final_res;

  modport source (output valid, position, edge_visit, seek_total, dropped, final_res,
                  input ready);
  modport sink   (input valid, position, edge_visit, seek_total, dropped, final_res,
                  output ready);
endinterface

FILE: design/sds_store.sv
// sds_store: request store, one write and one registered read per cycle.
// Depends on sds_pkg.
module sds_store import sds_pkg::*; (
  input  logic                clk_i,
  input  mem_req_t            req_i,
  output logic [CYL_BITS-1:0] rdata_o
);

  logic [CYL_BITS-1:0] mem [MAX_REQUESTS];
  logic [CYL_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/sds_alu.sv
// sds_alu: shared compare / distance unit (one subtract).
// Depends on sds_pkg.
module sds_alu import sds_pkg::*; (
  input  logic [CYL_BITS-1:0] a_i,
  input  logic [CYL_BITS-1:0] b_i,
  output alu_res_t            res_o
);

  logic [CYL_BITS:0] diff;

  assign diff        = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.lt    = diff[CYL_BITS];
  assign res_o.gt    = !diff[CYL_BITS] && (diff[CYL_BITS-1:0] != '0);
  // negate when a < b to get |a - b|
  assign res_o.delta = diff[CYL_BITS] ? (CYL_BITS'(0) - diff[CYL_BITS-1:0])
                                      : diff[CYL_BITS-1:0];

endmodule

FILE: design/scan_disk_scheduler.sv
// scan_disk_scheduler: SCAN (elevator) disk scheduler top level.
// Depends on sds_pkg, sds_req_if, sds_res_if, sds_store, sds_alu.
//
//  channel  | dir | payload                                         | handshake
//  ---------+-----+-------------------------------------------------+-------------
//  req      | in  | cylinder[15:0], last                            | valid/ready
//  res      | out | position[15:0], edge_visit, seek_total[21:0],   | valid/ready
//           |     | dropped, final_res                              |
//  cfg      | in  | cfg_idx_i[1:0], cfg_data_i[16:0]                | cfg_we_i
//
// Sequence: a request transfer is followed by an insertion walk through the
//   store that moves k larger entries up one slot each (k = 0..31).
// A request flagged last then starts the run: the stored requests below/above the
//   head are read and compared to find the split point, then each result, with an
//   edge visit at the turnaround, is read, added to the seek total and held until the sink takes it.
//   All compares and the seek distance go through the single sds_alu subtractor.
// Reset clears config to defaults and empties the batch; the store itself
//   is not cleared (only entries below the count are ever used).
// req.ready is high only while idle; one result is offered at a time.
module scan_disk_scheduler import sds_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  sds_req_if.sink               req,
  sds_res_if.source             res
);

  // config registers
  logic [CYL_BITS-1:0] start_head_q;
  logic [COUNT_W-1:0]  cyl_count_q;
  logic                sweep_up_q;

  // sequencer state
  state_e              state_q, state_d;
  phase_e              phase_q, phase_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                ovf_q, ovf_d;
  logic [CNT_W-1:0]    idx_q, idx_d;       // insertion slot
  logic [CNT_W-1:0]    split_q, split_d;
  logic [CNT_W-1:0]    ptr_q, ptr_d;
  logic [CYL_BITS-1:0] cyl_q, cyl_d;
  logic                last_q, last_d;
  logic [CYL_BITS-1:0] head_q, head_d;     // doubles as result position
  logic [SEEK_W-1:0]   seek_q, seek_d;
  logic                src_mem_q, src_mem_d;
  logic                is_edge_q, is_edge_d;
  logic                final_q, final_d;

  // datapath helpers
  logic [CYL_BITS-1:0] hi_edge;
  logic [COUNT_W-1:0]  cnt_m1;
  logic [CYL_BITS-1:0] alu_a, alu_b;
  alu_res_t            alu;
  mem_req_t            mem_req;
  logic [CYL_BITS-1:0] rdata;
  logic [CYL_BITS-1:0] pos;
  logic [SEEK_W:0]     seek_sum;
  logic                req_xfer, res_xfer;
  logic                asc, run_done, below;

  sds_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  sds_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu)
  );

  assign req_xfer = req.valid && req.ready;
  assign res_xfer = res.valid && res.ready;

  // high edge: count - 1, zero count treated as one, saturated to the cylinder range
  assign cnt_m1 = cyl_count_q - COUNT_W'(1);
  always_comb begin
    if (cyl_count_q == '0) begin
      hi_edge = '0;
    end else if (cnt_m1 > COUNT_W'({CYL_BITS{1'b1}})) begin
      hi_edge = '1;
    end else begin
      hi_edge = cnt_m1[CYL_BITS-1:0];
    end
  end

  // run direction: first run follows sweep_up, second run the other way
  assign asc      = ((phase_q == PH_RUN_A) == sweep_up_q);
  assign run_done = asc ? (ptr_q == count_q) : (ptr_q == '0);
  assign below    = sweep_up_q ? alu.lt : !alu.gt;
  assign pos      = src_mem_q ? rdata : (sweep_up_q ? hi_edge : '0);
  assign seek_sum = {1'b0, seek_q} + (SEEK_W + 1)'(alu.delta);

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_head_q <= '0;
      cyl_count_q  <= CYL_COUNT_RST;
      sweep_up_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_HEAD: start_head_q <= cfg_data_i[CYL_BITS-1:0];
        CFG_CYL_COUNT:  cyl_count_q  <= cfg_data_i[COUNT_W-1:0];
        CFG_SWEEP_UP:   sweep_up_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_xfer) state_d = S_INS;
      end
      S_INS: begin
        if (count_q == CNT_W'(MAX_REQUESTS) || idx_q == '0) begin
          state_d = last_q ? S_RUN_INIT : S_IDLE;
        end else begin
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (alu.gt) begin
          state_d = (idx_q == CNT_W'(1)) ? S_INS : S_INS_CMP;
        end else begin
          state_d = last_q ? S_RUN_INIT : S_IDLE;
        end
      end
      S_RUN_INIT: state_d = S_SPLIT;
      S_SPLIT: begin
        state_d = (split_q == count_q) ? S_EMIT : S_SPLIT_CMP;
      end
      S_SPLIT_CMP: begin
        state_d = below ? S_SPLIT : S_EMIT;
      end
      S_EMIT: begin
        if (phase_q == PH_TURN || !run_done) begin
          state_d = S_CALC;
        end else if (phase_q == PH_RUN_B) begin
          state_d = S_IDLE;   // unreachable: the last result ends the run
        end
      end
      S_CALC: state_d = S_OUT;
      S_OUT: begin
        if (res_xfer) state_d = final_q ? S_IDLE : S_EMIT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    idx_d     = idx_q;
    split_d   = split_q;
    ptr_d     = ptr_q;
    cyl_d     = cyl_q;
    last_d    = last_q;
    head_d    = head_q;
    seek_d    = seek_q;
    src_mem_d = src_mem_q;
    is_edge_d = is_edge_q;
    final_d   = final_q;
    alu_a     = '0;
    alu_b     = '0;
    mem_req   = '0;

    case (state_q)
      S_IDLE: begin
        alu_a = req.cylinder;
        alu_b = hi_edge;
        if (req_xfer) begin
          cyl_d  = alu.gt ? hi_edge : req.cylinder;
          last_d = req.last;
          idx_d  = count_q;
        end
      end
      S_INS: begin
        if (count_q == CNT_W'(MAX_REQUESTS)) begin
          ovf_d = 1'b1;
        end else if (idx_q == '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = '0;
          mem_req.wdata = cyl_q;
          count_d       = count_q + CNT_W'(1);
        end else begin
          mem_req.raddr = IDX_W'(idx_q - CNT_W'(1));
        end
      end
      S_INS_CMP: begin
        alu_a         = rdata;
        alu_b         = cyl_q;
        mem_req.we    = 1'b1;
        mem_req.waddr = IDX_W'(idx_q);
        if (alu.gt) begin
          // shift the larger entry up one slot, fetch the next one down
          mem_req.wdata = rdata;
          idx_d         = idx_q - CNT_W'(1);
          mem_req.raddr = IDX_W'(idx_q - CNT_W'(2));
        end else begin
          mem_req.wdata = cyl_q;
          count_d       = count_q + CNT_W'(1);
        end
      end
      S_RUN_INIT: begin
        alu_a   = start_head_q;
        alu_b   = hi_edge;
        head_d  = alu.gt ? hi_edge : start_head_q;
        seek_d  = '0;
        split_d = '0;
      end
      S_SPLIT: begin
        mem_req.raddr = IDX_W'(split_q);
        if (split_q == count_q) begin
          ptr_d   = split_q;
          phase_d = PH_RUN_A;
        end
      end
      S_SPLIT_CMP: begin
        alu_a = rdata;
        alu_b = head_q;
        if (below) begin
          split_d = split_q + CNT_W'(1);
        end else begin
          ptr_d   = split_q;
          phase_d = PH_RUN_A;
        end
      end
      S_EMIT: begin
        if (phase_q == PH_TURN) begin
          src_mem_d = 1'b0;
          is_edge_d = 1'b1;
          phase_d   = PH_RUN_B;
          ptr_d     = split_q;
          final_d   = sweep_up_q ? (split_q == '0) : (split_q == count_q);
        end else if (run_done) begin
          if (phase_q == PH_RUN_A) begin
            phase_d = PH_TURN;
          end else begin
            count_d = '0;
            ovf_d   = 1'b0;
          end
        end else begin
          mem_req.raddr = asc ? IDX_W'(ptr_q) : IDX_W'(ptr_q - CNT_W'(1));
          ptr_d         = asc ? (ptr_q + CNT_W'(1)) : (ptr_q - CNT_W'(1));
          src_mem_d     = 1'b1;
          is_edge_d     = 1'b0;
          final_d       = (phase_q == PH_RUN_B) &&
                          (asc ? (ptr_q + CNT_W'(1) == count_q) : (ptr_q == CNT_W'(1)));
        end
      end
      S_CALC: begin
        alu_a  = pos;
        alu_b  = head_q;
        head_d = pos;
        seek_d = seek_sum[SEEK_W] ? '1 : seek_sum[SEEK_W-1:0];
      end
      S_OUT: begin
        if (res_xfer && final_q) begin
          count_d = '0;
          ovf_d   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // channel outputs
  assign req.ready      = (state_q == S_IDLE);
  assign res.valid      = (state_q == S_OUT);
  assign res.position   = head_q;
  assign res.edge_visit = is_edge_q;
  assign res.seek_total = seek_q;
  assign res.dropped    = ovf_q;
  assign res.final_res  = final_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_RUN_A;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    split_q   <= split_d;
    ptr_q     <= ptr_d;
    cyl_q     <= cyl_d;
    last_q    <= last_d;
    head_q    <= head_d;
    seek_q    <= seek_d;
    src_mem_q <= src_mem_d;
    is_edge_q <= is_edge_d;
    final_q   <= final_d;
  end

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_REQUESTS))
    else $error("request count above capacity");

  a_req_starts_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer |=> (state_q == S_INS))
    else $error("request transfer did not start insertion");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_xfer && final_q) |=> (count_q == '0 && !ovf_q && state_q == S_IDLE))
    else $error("batch not cleared after final result");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (ptr_q <= count_q && split_q <= count_q))
    else $error("emit pointer outside stored requests");

endmodule
